// ===== rtl/double_ended_priority_queue_top_defines.svh =====
// Assertion shorthands for the priority queue. Each expects clk and rst_n in scope.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Condition holds at every edge out of reset
`define DEPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define DEPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define DEPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/depq_pkg.sv =====
package depq_pkg;

  // Default number of entries
  localparam int DEPTH_DEFAULT = 16;

  // Request codes
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DEL_HEAD = 2'd1,
    OP_DEL_MAX  = 2'd2,
    OP_DEL_MIN  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // One stored entry
  typedef struct packed {
    logic        [31:0] payload;
    logic signed [31:0] prio;
  } entry_t;

endpackage

// ===== rtl/depq_if.sv =====
// Request channel
interface depq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] payload_in;
  logic [31:0] priority_in;

  modport source (output valid, operation, payload_in, priority_in, input ready);
  modport sink   (input valid, operation, payload_in, priority_in, output ready);
endinterface

// Result channel
interface depq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] payload_out;
  logic [4:0]  occupancy;

  modport source (output valid, status, payload_out, occupancy, input ready);
  modport sink   (input valid, status, payload_out, occupancy, output ready);
endinterface

// ===== rtl/double_ended_priority_queue_top.sv =====
// Channel   Direction  Fields                                 Transaction
// in_chan   input      operation, payload_in, priority_in     valid && ready
// out_chan  output     status, payload_out, occupancy         valid && ready
//
// Insert and any failed request: after acceptance the result is registered in S_DONE.
// Delete-oldest with n entries: S_SHIFT moves the later entries down (n-1 shifts).
// Delete-max/min with n entries: S_SCAN reads all n, then S_SHIFT closes the gap unless it was last.
// The entry store has a single read and a single write port; a request is taken only in S_IDLE.
// rst_n is synchronous; it clears the count and control, the store is left as is.
// A result held on out_chan lets the next request in but holds it in S_DONE until taken.
module double_ended_priority_queue_top #(
  parameter int DEPTH = depq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  depq_in_if.sink           in_chan,
  depq_out_if.source        out_chan
);

  `include "double_ended_priority_queue_top_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [AW-1:0]           best_pos_r, best_pos_nxt;
  logic signed [31:0]      best_pri_r, best_pri_nxt;
  logic [31:0]             best_pay_r, best_pay_nxt;
  logic                    want_max_r, want_max_nxt;
  depq_pkg::status_t       res_status_r, res_status_nxt;
  logic [31:0]             res_payload_r, res_payload_nxt;
  logic                    out_valid_r, out_valid_nxt;
  depq_pkg::status_t       out_status_r, out_status_nxt;
  logic [31:0]             out_payload_r, out_payload_nxt;
  logic [4:0]              out_occ_r, out_occ_nxt;

  logic                    we;
  logic [AW-1:0]           waddr;
  depq_pkg::entry_t        wdata;
  logic [AW-1:0]           raddr;
  depq_pkg::entry_t        rd_data;

  logic                    in_accept;
  depq_pkg::op_t           op;
  logic                    take;
  logic                    scan_last;
  logic                    shift_last;

  logic                    ins_room;
  logic                    shift_in_span;
  logic                    scan_in_span;

  // Address of base + step, parked at zero past the end of the store
  function automatic logic [AW-1:0] step_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] step);
    logic [CW-1:0] sum;
    sum = CW'(base) + step;
    return (sum < CW'(DEPTH)) ? sum[AW-1:0] : '0;
  endfunction

  depq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign in_accept       = in_chan.valid && in_chan.ready;
  assign op              = depq_pkg::op_t'(in_chan.operation);
  assign in_chan.ready   = (state_r == S_IDLE);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.payload_out = out_payload_r;
  assign out_chan.occupancy   = out_occ_r;

  // Scan compare: first entry always taken, strict compare keeps the oldest on ties
  assign take = (idx_r == '0) ||
                (want_max_r ? (rd_data.prio > best_pri_r) : (rd_data.prio < best_pri_r));
  assign best_pos_nxt = take ? idx_r : best_pos_r;
  assign best_pri_nxt = take ? rd_data.prio : best_pri_r;
  assign best_pay_nxt = take ? rd_data.payload : best_pay_r;

  assign scan_last  = (CW'(idx_r) == count_r - CW'(1));
  assign shift_last = (CW'(idx_r) == count_r - CW'(2));

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    want_max_nxt    = want_max_r;
    res_status_nxt  = res_status_r;
    res_payload_nxt = res_payload_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_payload_nxt = out_payload_r;
    out_occ_nxt     = out_occ_r;
    we              = 1'b0;
    waddr           = idx_r;
    wdata           = rd_data;
    raddr           = '0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        raddr = (op == depq_pkg::OP_DEL_HEAD) ? AW'(1) : '0;
        if (in_accept) begin
          res_payload_nxt = '0;
          res_status_nxt  = depq_pkg::STAT_OK;
          want_max_nxt    = (op == depq_pkg::OP_DEL_MAX);
          idx_nxt         = '0;
          state_nxt       = S_DONE;
          unique case (op)
            depq_pkg::OP_INSERT: begin
              if (count_r < CW'(DEPTH)) begin
                we            = 1'b1;
                waddr         = count_r[AW-1:0];
                wdata.payload = in_chan.payload_in;
                wdata.prio    = in_chan.priority_in;
                count_nxt     = count_r + CW'(1);
              end else begin
                res_status_nxt = depq_pkg::STAT_FULL;
              end
            end
            depq_pkg::OP_DEL_HEAD: begin
              if (count_r == '0) begin
                res_status_nxt = depq_pkg::STAT_EMPTY;
              end else if (count_r == CW'(1)) begin
                count_nxt = '0;
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            depq_pkg::OP_DEL_MAX, depq_pkg::OP_DEL_MIN: begin
              if (count_r == '0) begin
                res_status_nxt = depq_pkg::STAT_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_last) begin
          raddr           = step_addr(best_pos_nxt, CW'(1));
          res_payload_nxt = best_pay_nxt;
          if (CW'(best_pos_nxt) == count_r - CW'(1)) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = best_pos_nxt;
            state_nxt = S_SHIFT;
          end
        end else begin
          raddr   = step_addr(idx_r, CW'(1));
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_SHIFT: begin
        // Entry idx+1 arrives now and moves down to idx
        we    = 1'b1;
        waddr = idx_r;
        wdata = rd_data;
        raddr = step_addr(idx_r, CW'(2));
        if (shift_last) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_payload_nxt = res_payload_r;
          out_occ_nxt     = 5'(count_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    want_max_r    <= want_max_nxt;
    res_status_r  <= res_status_nxt;
    res_payload_r <= res_payload_nxt;
    out_status_r  <= out_status_nxt;
    out_payload_r <= out_payload_nxt;
    out_occ_r     <= out_occ_nxt;
    if (state_r == S_SCAN) begin
      best_pos_r <= best_pos_nxt;
      best_pri_r <= best_pri_nxt;
      best_pay_r <= best_pay_nxt;
    end
  end

  // Checks
  assign ins_room      = in_accept && op == depq_pkg::OP_INSERT && count_r < CW'(DEPTH);
  assign shift_in_span = count_r >= CW'(2) && CW'(idx_r) <= count_r - CW'(2);
  assign scan_in_span  = count_r != '0 && CW'(idx_r) < count_r;

  `DEPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "entry count exceeds depth")
  `DEPQ_ASSERT_NEXT(a_insert_grows, ins_room, count_r == $past(count_r) + CW'(1), "insert lost")
  `DEPQ_ASSERT_IMPL(a_shift_span, state_r == S_SHIFT, shift_in_span, "shift out of range")
  `DEPQ_ASSERT_IMPL(a_scan_span, state_r == S_SCAN, scan_in_span, "scan out of range")

endmodule

// ===== rtl/depq_ram.sv =====
// Entry store: one write port, one read port, registered read data
module depq_ram #(
  parameter int DEPTH = depq_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  depq_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output depq_pkg::entry_t rdata
);

  depq_pkg::entry_t mem [DEPTH];
  depq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
